// ----- rtl/core/dsv_pkg.sv -----
`default_nettype none

package dsv_pkg;

  // character codes
  localparam logic [7:0] SLASH_CODE = 8'h2F;
  localparam logic [7:0] ZERO_CODE  = 8'h30;
  localparam logic [7:0] NINE_CODE  = 8'h39;

  // length and count limits
  localparam logic [3:0] MIN_LEN   = 4'd6;
  localparam logic [3:0] MAX_LEN   = 4'd10;
  localparam logic [3:0] LEN_SAT   = 4'd11;
  localparam logic [2:0] DM_CAP    = 3'd2;
  localparam logic [2:0] YEAR_CAP  = 3'd4;
  localparam logic [2:0] DIGIT_SAT = 3'd7;
  localparam logic [6:0] MONTHS    = 7'd12;
  localparam logic [4:0] LEAP_FEB  = 5'd29;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    TOK_DIGIT,
    TOK_SLASH,
    TOK_OTHER
  } tok_kind_t;

  typedef enum logic [1:0] {
    PH_DAY,
    PH_MONTH,
    PH_YEAR
  } phase_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  digit;
    logic        last;
  } dsv_tok_t;

  // parse state of one string, also the snapshot handed to the verdict stage
  typedef struct packed {
    logic        err;
    phase_t      phase;
    logic [2:0]  digits;
    logic [3:0]  len;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [13:0] year;
    logic [4:0]  ymod25;
  } dsv_snap_t;

  localparam dsv_snap_t ST_IDLE = dsv_snap_t'('0);

  // (r * 10 + d) mod 25 for r < 25, by reciprocal multiply
  function automatic logic [4:0] mod25_step(input logic [4:0] r, input logic [3:0] d);
    logic [7:0]  v;
    logic [15:0] p;
    logic [3:0]  q;
    logic [7:0]  rem;
    v   = 8'(r) * 8'd10 + 8'(d);
    p   = 16'(v) * 16'd164;
    q   = p[15:12];
    rem = v - 8'(q) * 8'd25;
    return rem[4:0];
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? LEAP_FEB : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dsv_front.sv -----
`default_nettype none

module dsv_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_char_code,
  input  wire logic             in_is_last,
  output logic                  tok_valid,
  input  wire logic             tok_ready,
  output dsv_pkg::dsv_tok_t     tok
);
  import dsv_pkg::*;

  logic      tok_v_r, tok_v_nxt;
  dsv_tok_t  tok_r, tok_nxt;
  logic      load;

  assign in_ready  = !tok_v_r || tok_ready;
  assign load      = in_valid && in_ready;
  assign tok_valid = tok_v_r;
  assign tok       = tok_r;

  // classify the character
  always_comb begin
    tok_nxt       = tok_r;
    tok_v_nxt     = tok_v_r;
    if (load) begin
      tok_v_nxt     = 1'b1;
      tok_nxt.last  = in_is_last;
      tok_nxt.digit = 4'(in_char_code - ZERO_CODE);
      if (in_char_code == SLASH_CODE) begin
        tok_nxt.kind = TOK_SLASH;
      end else if (in_char_code >= ZERO_CODE && in_char_code <= NINE_CODE) begin
        tok_nxt.kind = TOK_DIGIT;
      end else begin
        tok_nxt.kind = TOK_OTHER;
      end
    end else if (tok_ready) begin
      tok_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_v_nxt;
    end
    tok_r <= tok_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/dsv_fifo.sv -----
`default_nettype none

module dsv_fifo #(
  parameter int DEPTH = dsv_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire dsv_pkg::dsv_tok_t push_tok,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output dsv_pkg::dsv_tok_t      pop_tok
);
  import dsv_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dsv_tok_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_tok    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dsv_back.sv -----
`default_nettype none

module dsv_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              tok_valid,
  output logic                   tok_ready,
  input  wire dsv_pkg::dsv_tok_t tok,
  output logic                   snap_valid,
  input  wire logic              snap_ready,
  output dsv_pkg::dsv_snap_t     snap
);
  import dsv_pkg::*;

  dsv_snap_t   st_r, st_nxt;
  dsv_snap_t   upd;
  dsv_snap_t   snap_r, snap_nxt;
  logic        snap_v_r, snap_v_nxt;
  logic        pop;
  logic [2:0]  cap;
  logic [10:0] day_ext, month_ext;
  logic [17:0] year_ext;

  // a final word waits until the verdict stage has room
  assign tok_ready  = !tok.last || snap_ready;
  assign pop        = tok_valid && tok_ready;
  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

  assign cap       = (st_r.phase == PH_YEAR) ? YEAR_CAP : DM_CAP;
  assign day_ext   = 11'(st_r.day) * 11'd10 + 11'(tok.digit);
  assign month_ext = 11'(st_r.month) * 11'd10 + 11'(tok.digit);
  assign year_ext  = 18'(st_r.year) * 18'd10 + 18'(tok.digit);

  always_comb begin
    upd = st_r;
    if (st_r.len < LEN_SAT) begin
      upd.len = st_r.len + 4'd1;
    end
    case (tok.kind)
      TOK_SLASH: begin
        if (st_r.phase == PH_YEAR) begin
          upd.err = 1'b1;
        end else begin
          if (st_r.digits == 3'd0 || st_r.digits > DM_CAP) begin
            upd.err = 1'b1;
          end
          upd.phase  = (st_r.phase == PH_DAY) ? PH_MONTH : PH_YEAR;
          upd.digits = 3'd0;
        end
      end
      TOK_DIGIT: begin
        if (st_r.digits < cap) begin
          unique case (st_r.phase)
            PH_DAY:   upd.day   = day_ext[6:0];
            PH_MONTH: upd.month = month_ext[6:0];
            PH_YEAR: begin
              upd.year   = year_ext[13:0];
              upd.ymod25 = mod25_step(st_r.ymod25, tok.digit);
            end
            default:  upd.err   = 1'b1;
          endcase
        end
        if (st_r.digits < DIGIT_SAT) begin
          upd.digits = st_r.digits + 3'd1;
        end
      end
      default: upd.err = 1'b1;
    endcase
  end

  always_comb begin
    st_nxt     = st_r;
    snap_nxt   = snap_r;
    snap_v_nxt = snap_v_r;
    if (snap_v_r && snap_ready) begin
      snap_v_nxt = 1'b0;
    end
    if (pop) begin
      if (tok.last) begin
        st_nxt     = ST_IDLE;
        snap_nxt   = upd;
        snap_v_nxt = 1'b1;
      end else begin
        st_nxt = upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      snap_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      snap_v_r <= snap_v_nxt;
    end
    snap_r <= snap_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/dsv_judge.sv -----
`default_nettype none

module dsv_judge (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               snap_valid,
  output logic                    snap_ready,
  input  wire dsv_pkg::dsv_snap_t snap,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_date_valid,
  output logic [6:0]              out_day_value,
  output logic [6:0]              out_month_value,
  output logic [13:0]             out_year_value
);
  import dsv_pkg::*;

  logic        out_v_r, out_v_nxt;
  logic        ok_r, ok_nxt;
  logic [6:0]  day_r, month_r;
  logic [13:0] year_r;
  logic        load, leap, fmt_ok;
  logic [4:0]  lim;

  assign snap_ready = !out_v_r || out_ready;
  assign load       = snap_valid && snap_ready;

  // gregorian leap test: mod 4/16 from low bits, mod 25 tracked during parse
  assign leap = (snap.year[1:0] == 2'd0 && snap.ymod25 != 5'd0) ||
                (snap.year[3:0] == 4'd0 && snap.ymod25 == 5'd0);
  assign lim  = month_len(snap.month[3:0], leap);

  assign fmt_ok = !snap.err && snap.phase == PH_YEAR &&
                  (snap.digits == DM_CAP || snap.digits == YEAR_CAP) &&
                  snap.len >= MIN_LEN && snap.len <= MAX_LEN &&
                  snap.month >= 7'd1 && snap.month <= MONTHS;
  assign ok_nxt = fmt_ok && snap.day >= 7'd1 && snap.day <= 7'(lim);

  always_comb begin
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
    if (load) begin
      ok_r    <= ok_nxt;
      day_r   <= snap.day;
      month_r <= snap.month;
      year_r  <= snap.year;
    end
  end

  assign out_valid       = out_v_r;
  assign out_date_valid  = ok_r;
  assign out_day_value   = day_r;
  assign out_month_value = month_r;
  assign out_year_value  = year_r;

endmodule

`default_nettype wire

// ----- rtl/core/date_string_validator.sv -----
// path: front token register, queue, back-end snapshot register, then the output register
// throughput: one character per cycle unless a full queue or a busy verdict stage stalls the input
// one verdict per string, issued only for a character flagged as last
// reset: synchronous active-low rst_n empties the input stage, queue and output register
// and returns the parse state to the start of the day field
`default_nettype none

module date_string_validator #(
  parameter int QUEUE_DEPTH = dsv_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_date_valid,
  output logic [6:0]       out_day_value,
  output logic [6:0]       out_month_value,
  output logic [13:0]      out_year_value
);
  import dsv_pkg::*;

  // front end: registers each incoming word and classifies it as digit, slash or other
  logic      ftok_valid, ftok_ready;
  dsv_tok_t  ftok;

  // queue output toward the back end
  logic      qtok_valid, qtok_ready;
  dsv_tok_t  qtok;

  // finished parse state of one string, waiting for the verdict stage
  logic      snap_valid, snap_ready;
  dsv_snap_t snap;

  dsv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_is_last   (in_is_last),
    .tok_valid    (ftok_valid),
    .tok_ready    (ftok_ready),
    .tok          (ftok)
  );

  // short queue so the front end keeps taking words while the back end stalls, until it is full
  dsv_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (ftok_valid),
    .push_ready (ftok_ready),
    .push_tok   (ftok),
    .pop_valid  (qtok_valid),
    .pop_ready  (qtok_ready),
    .pop_tok    (qtok)
  );

  // back end: field/digit/length tracking and day, month, year accumulation
  dsv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (qtok_valid),
    .tok_ready  (qtok_ready),
    .tok        (qtok),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // verdict: format checks, month table with leap february, output register
  dsv_judge u_judge (
    .clk             (clk),
    .rst_n           (rst_n),
    .snap_valid      (snap_valid),
    .snap_ready      (snap_ready),
    .snap            (snap),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_date_valid  (out_date_valid),
    .out_day_value   (out_day_value),
    .out_month_value (out_month_value),
    .out_year_value  (out_year_value)
  );

  // a new verdict only appears after a snapshot was waiting
  a_out_from_snap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(snap_valid))
    else $error("verdict without a finished string");

  // a valid verdict always carries day, month and year values within range
  a_valid_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_date_valid) |->
      (out_month_value >= 7'd1 && out_month_value <= 7'd12 &&
       out_day_value >= 7'd1 && out_day_value <= 7'd31 &&
       out_year_value <= 14'd9999))
    else $error("valid verdict with out-of-range date");

  // a stalled snapshot is not overwritten
  a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (snap_valid && !snap_ready) |=> (snap_valid && $stable(snap)))
    else $error("snapshot lost while verdict stage was busy");

endmodule

`default_nettype wire

// ----- test/date_string_validator_test.sv -----
`timescale 1ns / 100ps

module date_string_validator_test;
  import dsv_pkg::*;

  // one verdict as the block should report it
  typedef struct {
    logic        ok;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [13:0] year;
  } date_verdict_t;

  // ways a well-formed date string gets broken
  typedef enum int {
    FLAW_NO_SLASH,
    FLAW_EXTRA_SLASH,
    FLAW_BAD_CHAR,
    FLAW_EXTRA_DIGITS,
    FLAW_CUT_SHORT,
    FLAW_OVERLONG,
    FLAW_EMPTY_DAY
  } flaw_t;

  // parses the character stream on the side and keeps the verdicts still owed
  class date_scoreboard;
    phase_t        phase;
    logic [2:0]    digits;
    logic [3:0]    length;
    logic [6:0]    day;
    logic [6:0]    month;
    logic [13:0]   year;
    logic          broken;
    date_verdict_t verdict_q[$];
    int unsigned   fails;

    function new();
      fails = 0;
      restart();
    endfunction

    function void restart();
      phase  = PH_DAY;
      digits = '0;
      length = '0;
      day    = '0;
      month  = '0;
      year   = '0;
      broken = 1'b0;
    endfunction

    function bit is_leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int days_in_month(int m, int y);
      int days [12];
      days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m < 1 || m > 12) return 31;
      if (m == 2 && is_leap_year(y)) return LEAP_FEB;
      return days[m - 1];
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // one accepted word: advance the parse, and on the last character queue a verdict
    function void note_char(logic [7:0] code, logic last);
      int            digit;
      logic [2:0]    cap;
      date_verdict_t v;
      if (length < LEN_SAT) length++;
      if (code == SLASH_CODE) begin
        if (phase == PH_YEAR) begin
          broken = 1'b1;
        end else begin
          if (digits < 1 || digits > DM_CAP) broken = 1'b1;
          phase  = (phase == PH_DAY) ? PH_MONTH : PH_YEAR;
          digits = '0;
        end
      end else if (code >= ZERO_CODE && code <= NINE_CODE) begin
        digit = int'(code - ZERO_CODE);
        cap   = (phase == PH_YEAR) ? YEAR_CAP : DM_CAP;
        if (digits < cap) begin
          case (phase)
            PH_DAY:   day   = 7'(int'(day) * 10 + digit);
            PH_MONTH: month = 7'(int'(month) * 10 + digit);
            default:  year  = 14'(int'(year) * 10 + digit);
          endcase
        end
        if (digits < DIGIT_SAT) digits++;
      end else begin
        broken = 1'b1;
      end
      if (!last) return;
      v.ok = !broken && phase == PH_YEAR && (digits == DM_CAP || digits == YEAR_CAP) &&
             length >= MIN_LEN && length <= MAX_LEN && month >= 1 && month <= MONTHS;
      if (v.ok && (day == 0 || day > days_in_month(month, year))) v.ok = 1'b0;
      v.day   = day;
      v.month = month;
      v.year  = year;
      verdict_q.push_back(v);
      restart();
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      fails++;
    endtask

    task check_verdict(logic ok, logic [6:0] d, logic [6:0] m, logic [13:0] y);
      date_verdict_t v;
      if (verdict_q.size() == 0) begin
        report($sformatf("verdict with none owed (valid=%0b %0d/%0d/%0d)", ok, d, m, y));
        return;
      end
      v = verdict_q.pop_front();
      if (ok !== v.ok) report($sformatf("date_valid %0b, want %0b", ok, v.ok));
      if (d !== v.day) report($sformatf("day_value %0d, want %0d", d, v.day));
      if (m !== v.month) report($sformatf("month_value %0d, want %0d", m, v.month));
      if (y !== v.year) report($sformatf("year_value %0d, want %0d", y, v.year));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_code;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  logic        out_date_valid;
  logic [6:0]  out_day_value;
  logic [6:0]  out_month_value;
  logic [13:0] out_year_value;

  date_scoreboard sb;
  logic [7:0]     text_q[$];     // characters of the string about to be sent
  int unsigned    words_sent = 0;
  bit             tx_idling  = 1'b0;
  bit             rx_idling  = 1'b1;
  bit             calm       = 1'b0;   // last stretch of the run: no idling at all

  date_string_validator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_date_valid (out_date_valid),
    .out_day_value  (out_day_value),
    .out_month_value(out_month_value),
    .out_year_value (out_year_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("date_string_validator_test NOT OK");
    $finish;
  end

  // result side: random stall bursts, with quiet stretches between them
  initial begin
    forever begin
      if (!calm && rx_idling && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 49) == 0) rx_idling = ($urandom_range(0, 2) != 0);
    end
  end

  // every accepted verdict goes to the scoreboard; pre-edge values are sampled
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_verdict(out_date_valid, out_day_value, out_month_value, out_year_value);
  end

  // one character word; an optional gap first, then hold until accepted
  task send_word(logic [7:0] code, logic last);
    if (!calm && tx_idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= code;
    in_is_last   <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_char(code, last);
    words_sent++;
  endtask

  task send_text();
    foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
  endtask

  // hold the input side until every owed verdict has come out
  task drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function void set_text(string s);
    text_q.delete();
    foreach (s[i]) text_q.push_back(8'(s[i]));
  endfunction

  // decimal with leading zeros, exactly nd digits
  function void push_num(int v, int nd);
    int div;
    div = 1;
    repeat (nd - 1) div *= 10;
    repeat (nd) begin
      text_q.push_back(8'(int'(ZERO_CODE) + (v / div) % 10));
      div /= 10;
    end
  endfunction

  // d/m/y with sane shape; values lean toward month ends and leap-year corners
  function void make_date();
    int m;
    int y;
    int d;
    int lim;
    int ylen;
    text_q.delete();
    m    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    ylen = $urandom_range(0, 1) ? int'(YEAR_CAP) : int'(DM_CAP);
    case ($urandom_range(0, 5))
      0:       y = 2000;
      1:       y = 1900;
      2:       y = 4 * $urandom_range(0, 2499);
      3:       y = 100 * $urandom_range(0, 99);
      default: y = $urandom_range(0, 9999);
    endcase
    if (ylen == DM_CAP) y = y % 100;
    lim = sb.days_in_month(m, y);
    case ($urandom_range(0, 6))
      0:       d = 0;
      1:       d = 1;
      2:       d = lim - 1;
      3:       d = lim;
      4:       d = lim + 1;
      5:       d = $urandom_range(0, 99);
      default: d = $urandom_range(1, lim);
    endcase
    push_num(d, (d < 10 && $urandom_range(0, 1)) ? 1 : 2);
    text_q.push_back(SLASH_CODE);
    push_num(m, (m < 10 && $urandom_range(0, 1)) ? 1 : 2);
    text_q.push_back(SLASH_CODE);
    push_num(y, ylen);
  endfunction

  function void break_date();
    int    slashes[$];
    int    pos;
    flaw_t flaw;
    logic [7:0] c;
    foreach (text_q[i]) if (text_q[i] == SLASH_CODE) slashes.push_back(i);
    pos  = $urandom_range(0, text_q.size() - 1);
    flaw = flaw_t'($urandom_range(0, 6));
    case (flaw)
      FLAW_NO_SLASH:    text_q.delete(slashes[$urandom_range(0, 1)]);
      FLAW_EXTRA_SLASH: text_q.insert(pos, SLASH_CODE);
      FLAW_BAD_CHAR: begin
        do c = 8'($urandom_range(0, 255));
        while (c == SLASH_CODE || (c >= ZERO_CODE && c <= NINE_CODE));
        text_q.insert(pos, c);
      end
      FLAW_EXTRA_DIGITS:
        repeat ($urandom_range(1, 3)) text_q.insert(pos, 8'(ZERO_CODE + $urandom_range(0, 9)));
      FLAW_CUT_SHORT: begin
        // sometimes right after a slash, so the string ends on it
        if ($urandom_range(0, 1)) pos = slashes[$urandom_range(0, 1)];
        while (text_q.size() > pos + 1) void'(text_q.pop_back());
      end
      FLAW_OVERLONG:
        repeat ($urandom_range(1, 4)) text_q.push_back(8'(ZERO_CODE + $urandom_range(0, 9)));
      default:          text_q.insert(0, SLASH_CODE);
    endcase
  endfunction

  // free-form junk: digits, slashes and any byte at all
  function void make_noise();
    int n;
    text_q.delete();
    n = $urandom_range(1, 14);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0:       text_q.push_back(8'(ZERO_CODE + $urandom_range(0, 9)));
        1:       text_q.push_back(SLASH_CODE);
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  initial begin
    sb = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_char_code <= '0;
    in_is_last   <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: year 2000 leap day, largest day/month, shortest legal string
    set_text("29/2/2000");
    send_text();
    set_text("31/12/99");
    send_text();
    set_text("1/1/00");
    send_text();
    // code zero and the top code as lone strings
    text_q = '{8'h00};
    send_text();
    text_q = '{8'hFF};
    send_text();
    // string ending on its slash, then a day with too many digits
    set_text("1//");
    send_text();
    set_text("123/4/56");
    send_text();
    drain();

    // random part: mostly well-formed dates, some broken, some pure noise
    while (words_sent < 1950) begin
      if ($urandom_range(0, 3) == 0) tx_idling = ($urandom_range(0, 2) != 0);
      calm = (words_sent > 1650);
      case ($urandom_range(0, 19))
        0, 1, 2: make_noise();
        3, 4, 5, 6, 7, 8: begin
          make_date();
          break_date();
        end
        default: make_date();
      endcase
      send_text();
      if ($urandom_range(0, 39) == 0) drain();
    end

    drain();
    repeat (12) @(posedge clk);
    if (sb.fails == 0)
      $display("date_string_validator_test OK");
    else
      $display("date_string_validator_test NOT OK");
    $finish;
  end

endmodule
